// File: sv/d2p_pkg.sv
// Shared types, widths and codes for the depth to point projection block.
package d2p_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int NEAR_W     = 24;
  localparam int RANGE_W    = 24;
  localparam int INV_W      = 25;
  localparam int SIZE_W     = 13;
  localparam int SIZE_MAX   = 8191;
  localparam int Z_W        = 25;
  localparam int MAG_W      = 13;
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Shared multiplier and accumulator widths.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LO_W   = MUL_W + MAG_W;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  // Configuration reset values.
  localparam logic [NEAR_W-1:0]  NEAR_RST   = 24'd1311;
  localparam logic [RANGE_W-1:0] RANGE_RST  = 24'd229376;
  localparam logic [INV_W-1:0]   INV_RST    = 25'd10923;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd480;

  // One classified request: raw sample plus signed pixel offsets.
  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic                x_neg;
    logic [MAG_W-1:0]    x_mag;
    logic                y_neg;
    logic [MAG_W-1:0]    y_mag;
    logic                eof;
  } d2p_item_t;

  // Arithmetic configuration used by the back end.
  typedef struct packed {
    logic [NEAR_W-1:0]  near_distance;
    logic [RANGE_W-1:0] depth_range;
    logic [INV_W-1:0]   inv_focal;
  } d2p_cfg_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Z,
    ST_P,
    ST_XL,
    ST_XH,
    ST_YL,
    ST_YH,
    ST_DONE
  } d2p_state_e;

endpackage

// File: sv/depth_to_point_projection.sv
// Each accepted request goes through the request queue to the back end sequencer, which
// shares one 25x25 multiplier over depth, focal scale and two partial products per axis
// and loads the point into the output register before it pops the next request.
// A two-entry queue lets the input accept requests while the back end works.
// Reset clears the pixel counters, queue and output valid, and loads register defaults.
// Top level: configuration registers, front end, request queue and back end.
module depth_to_point_projection import d2p_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_W-1:0]   depth_sample_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic [COORD_W-1:0]    point_x_o,
  output logic [COORD_W-1:0]    point_y_o,
  output logic [Z_W-1:0]        point_z_o,
  output logic                  end_of_frame_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  logic [NEAR_W-1:0]  near_q;
  logic [RANGE_W-1:0] range_q;
  logic [INV_W-1:0]   inv_q;
  logic [SIZE_W-1:0]  width_q;
  logic [SIZE_W-1:0]  height_q;
  d2p_cfg_t           cfg;
  d2p_item_t          push_item, pop_item;
  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= NEAR_RST;
      range_q  <= RANGE_RST;
      inv_q    <= INV_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NEAR:   near_q   <= cfg_data_i[NEAR_W-1:0];
        CFG_RANGE:  range_q  <= cfg_data_i[RANGE_W-1:0];
        CFG_INV:    inv_q    <= cfg_data_i[INV_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        default:    near_q   <= near_q;
      endcase
    end
  end

  assign cfg.near_distance = near_q;
  assign cfg.depth_range   = range_q;
  assign cfg.inv_focal     = inv_q;

  d2p_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .sample_i       (depth_sample_i),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .item_o         (push_item)
  );

  d2p_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  d2p_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .item_i         (pop_item),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .end_of_frame_o (end_of_frame_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

// File: sv/d2p_front.sv
// Front end: pixel counters and classification of each depth request.
module d2p_front import d2p_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIZE_W-1:0]   image_width_i,
  input  logic [SIZE_W-1:0]   image_height_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                valid_i,
  output logic                ready_o,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output d2p_item_t           item_o
);

  // The size registers cannot exceed SIZE_MAX, so larger limits never clip.
  localparam int MaxWClip = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
  localparam int MaxHClip = (MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT;
  localparam int ColW     = $clog2(MaxWClip);
  localparam int RowW     = $clog2(MaxHClip);
  localparam logic [SIZE_W-1:0] MaxW = SIZE_W'(MaxWClip);
  localparam logic [SIZE_W-1:0] MaxH = SIZE_W'(MaxHClip);

  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [SIZE_W-1:0]   col_cur, row_cur;
  logic [SIZE_W-1:0]   col, row;
  logic signed [SIZE_W+1:0] dx, dy;
  logic                last_col, last_row;
  logic                accept;

  assign ready_o      = push_ready_i;
  assign push_valid_o = valid_i;
  assign accept       = valid_i & push_ready_i;

  // Effective frame size: zero reads as one, oversize clips to the limit.
  always_comb begin
    if (image_width_i == '0) begin
      w_eff = SIZE_W'(1);
    end else if (image_width_i > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = image_width_i;
    end
    if (image_height_i == '0) begin
      h_eff = SIZE_W'(1);
    end else if (image_height_i > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = image_height_i;
    end
  end

  // A counter past a shrunk frame size is taken as the last column or row.
  always_comb begin
    col_cur  = SIZE_W'(col_q);
    row_cur  = SIZE_W'(row_q);
    col      = (col_cur >= w_eff) ? w_eff - SIZE_W'(1) : col_cur;
    row      = (row_cur >= h_eff) ? h_eff - SIZE_W'(1) : row_cur;
    last_col = (col == w_eff - SIZE_W'(1));
    last_row = (row == h_eff - SIZE_W'(1));
  end

  // Signed offsets from the optical center, in half pixels.
  always_comb begin
    dx = $signed({2'b00, w_eff}) - $signed({1'b0, col, 1'b0});
    dy = $signed({1'b0, row, 1'b0}) - $signed({2'b00, h_eff});
    item_o.raw   = sample_i;
    item_o.x_neg = dx[SIZE_W+1];
    item_o.x_mag = dx[SIZE_W+1] ? MAG_W'(-dx) : MAG_W'(dx);
    item_o.y_neg = dy[SIZE_W+1];
    item_o.y_mag = dy[SIZE_W+1] ? MAG_W'(-dy) : MAG_W'(dy);
    item_o.eof   = last_col & last_row;
  end

  // Raster counters advance on every accepted request.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : RowW'(row + SIZE_W'(1));
      end else begin
        col_d = ColW'(col + SIZE_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: sv/d2p_queue.sv
// Short request queue that decouples the front end from the back end.
module d2p_queue import d2p_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  d2p_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output d2p_item_t pop_item_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  d2p_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/d2p_back.sv
// Back end: sequencer around one shared multiplier that builds each point.
module d2p_back import d2p_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  d2p_cfg_t           cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  d2p_item_t          item_i,
  output logic [COORD_W-1:0] point_x_o,
  output logic [COORD_W-1:0] point_y_o,
  output logic [Z_W-1:0]     point_z_o,
  output logic               end_of_frame_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  localparam logic [LO_W:0]     RoundBit = (LO_W+1)'(1) << (MUL_W - 1);
  localparam logic [LO_W:0]     PosMax   = (LO_W+1)'(32'h7FFF_FFFF);
  localparam logic [LO_W:0]     NegMax   = (LO_W+1)'(32'h8000_0000);

  d2p_state_e          state_q, state_d;
  d2p_item_t           item_q;
  logic [Z_W-1:0]      z_q;
  logic [PROD_W-1:0]   p_q;
  logic [LO_W-1:0]     lo_q;
  logic [COORD_W-1:0]  x_q, y_q;
  logic [COORD_W-1:0]  out_x_q, out_y_q;
  logic [Z_W-1:0]      out_z_q;
  logic                out_eof_q;
  logic                out_valid_q, out_valid_d;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic [Z_W-1:0]      z_new;
  logic [MAG_W-1:0]    mag;
  logic                neg;
  logic [LO_W:0]       rounded;
  logic [COORD_W-1:0]  coord;
  logic                out_free;

  // Control strobes decoded from the state.
  logic ld_item, ld_z, ld_p, ld_lo, ld_x, ld_y, ld_out;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop_valid_i) state_d = ST_Z;
      ST_Z:    state_d = ST_P;
      ST_P:    state_d = ST_XL;
      ST_XL:   state_d = ST_XH;
      ST_XH:   state_d = ST_YL;
      ST_YL:   state_d = ST_YH;
      ST_YH:   state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: strobes and multiplier operands.
  always_comb begin
    ld_item     = 1'b0;
    ld_z        = 1'b0;
    ld_p        = 1'b0;
    ld_lo       = 1'b0;
    ld_x        = 1'b0;
    ld_y        = 1'b0;
    ld_out      = 1'b0;
    pop_ready_o = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    mag         = item_q.x_mag;
    neg         = item_q.x_neg;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        ld_item     = pop_valid_i;
      end
      ST_Z: begin
        mul_a = MUL_W'(cfg_i.depth_range);
        mul_b = MUL_W'(item_q.raw);
        ld_z  = 1'b1;
      end
      ST_P: begin
        mul_a = z_q;
        mul_b = cfg_i.inv_focal;
        ld_p  = 1'b1;
      end
      ST_XL: begin
        mul_a = p_q[MUL_W-1:0];
        mul_b = MUL_W'(item_q.x_mag);
        ld_lo = 1'b1;
      end
      ST_XH: begin
        mul_a = p_q[PROD_W-1:MUL_W];
        mul_b = MUL_W'(item_q.x_mag);
        ld_x  = 1'b1;
      end
      ST_YL: begin
        mul_a = p_q[MUL_W-1:0];
        mul_b = MUL_W'(item_q.y_mag);
        mag   = item_q.y_mag;
        neg   = item_q.y_neg;
        ld_lo = 1'b1;
      end
      ST_YH: begin
        mul_a = p_q[PROD_W-1:MUL_W];
        mul_b = MUL_W'(item_q.y_mag);
        mag   = item_q.y_mag;
        neg   = item_q.y_neg;
        ld_y  = 1'b1;
      end
      ST_DONE: begin
        ld_out = out_free;
      end
      default: begin
        ld_out = 1'b0;
      end
    endcase
  end

  // Shared multiplier.
  assign prod = mul_a * mul_b;

  // Depth: near clip plus the truncated scaled sample.
  assign z_new = Z_W'(cfg_i.near_distance) + Z_W'(prod[RANGE_W+SAMPLE_W-1:SAMPLE_W]);

  // Upper partial product plus the rounded lower one, then sign and saturation.
  always_comb begin
    rounded = (LO_W+1)'(prod[LO_W-1:0])
            + (LO_W+1)'(((LO_W+1)'(lo_q) + RoundBit) >> MUL_W);
    if (mag == '0) begin
      coord = '0;
    end else if (neg) begin
      coord = (rounded > NegMax) ? COORD_W'(NegMax) : COORD_W'(rounded);
      coord = -coord;
    end else begin
      coord = (rounded > PosMax) ? COORD_W'(PosMax) : COORD_W'(rounded);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ld_item) item_q <= item_i;
    if (ld_z)    z_q    <= z_new;
    if (ld_p)    p_q    <= prod;
    if (ld_lo)   lo_q   <= prod[LO_W-1:0];
    if (ld_x)    x_q    <= coord;
    if (ld_y)    y_q    <= coord;
    if (ld_out) begin
      out_x_q   <= x_q;
      out_y_q   <= y_q;
      out_z_q   <= z_q;
      out_eof_q <= item_q.eof;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign point_z_o      = out_z_q;
  assign end_of_frame_o = out_eof_q;
  assign out_valid_o    = out_valid_q;

endmodule
